>>> rtl/mwo_pkg.sv
// Shared types, register indexes and defaults for the mixed waveform oscillator.
package mwo_pkg;

  // Default widths of the phase accumulator and of one output sample
  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Configuration port widths
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int STEP_BITS      = 32;
  localparam int PW_BITS        = 17;

  // Pulse width is in units of 1/65536 of a cycle
  localparam int PW_FRAC_BITS = 16;
  localparam logic [PW_BITS-1:0] PW_FULL  = 17'd65536;
  localparam logic [PW_BITS-1:0] PW_RESET = 17'd32768;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PHASE_STEP  = 3'd0,
    REG_PULSE_WIDTH = 3'd1,
    REG_SAW_ON      = 3'd2,
    REG_SQUARE_ON   = 3'd3,
    REG_TRIANGLE_ON = 3'd4
  } reg_index_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [STEP_BITS-1:0] phase_step;
    logic [PW_BITS-1:0]   pulse_width;
    logic                 saw_on;
    logic                 square_on;
    logic                 triangle_on;
  } cfg_t;

endpackage

>>> rtl/mwo_cfg.sv
// Configuration register file of the mixed waveform oscillator.
module mwo_cfg
  import mwo_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output cfg_t                      cfg
);

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step  <= '0;
      cfg.pulse_width <= PW_RESET;
      cfg.saw_on      <= 1'b0;
      cfg.square_on   <= 1'b0;
      cfg.triangle_on <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_PHASE_STEP:  cfg.phase_step  <= cfg_data[STEP_BITS-1:0];
        REG_PULSE_WIDTH: cfg.pulse_width <= cfg_data[PW_BITS-1:0];
        REG_SAW_ON:      cfg.saw_on      <= cfg_data[0];
        REG_SQUARE_ON:   cfg.square_on   <= cfg_data[0];
        REG_TRIANGLE_ON: cfg.triangle_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mwo_phase.sv
// Phase accumulator and input stage of the mixed waveform oscillator.
module mwo_phase
  import mwo_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  restart,
  input  logic [STEP_BITS-1:0]  phase_step,
  input  logic                  advance,
  output logic                  phase_valid,
  output logic [PHASE_BITS-1:0] phase
);

  localparam int SUM_BITS = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS;

  logic [PHASE_BITS-1:0] phase_accum;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [SUM_BITS-1:0]   phase_sum;
  logic [PHASE_BITS-1:0] phase_accum_next;
  logic                  accept;

  // Hold the input while the staged item cannot move on
  assign in_stall = phase_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Restart zeroes the phase used for this item; the step wraps modulo the phase width
  assign phase_cur        = restart ? '0 : phase_accum;
  assign phase_sum        = SUM_BITS'(phase_cur) + SUM_BITS'(phase_step);
  assign phase_accum_next = phase_sum[PHASE_BITS-1:0];

  // Advance the accumulator and track the staged item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accum <= '0;
      phase_valid <= 1'b0;
    end else if (accept) begin
      phase_accum <= phase_accum_next;
      phase_valid <= 1'b1;
    end else if (advance) begin
      phase_valid <= 1'b0;
    end
  end

  // Capture the phase of the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      phase <= phase_cur;
    end
  end

endmodule

>>> rtl/mwo_mix.sv
// Waveform generation, mixing, scaling and output register.
module mwo_mix
  import mwo_pkg::*;
#(
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          phase_valid,
  input  logic [PHASE_BITS-1:0]         phase,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  // Phase fraction bits used by saw and triangle
  localparam int TOP_BITS = SAMPLE_BITS + 1;
  localparam int EXT_BITS = (PHASE_BITS > TOP_BITS) ? PHASE_BITS : TOP_BITS;
  // Signed width of one wave and of a sum of three
  localparam int SUM_BITS = SAMPLE_BITS + 3;
  // Magnitude of a sum stays below 2^MAG_BITS
  localparam int MAG_BITS = SAMPLE_BITS + 1;
  // Reciprocal of three with enough fraction bits for exact floor
  localparam int RCP_BITS = MAG_BITS + 1;
  localparam int PROD_BITS = MAG_BITS + RCP_BITS;
  localparam logic [RCP_BITS-1:0] RCP3 = RCP_BITS'((2 ** RCP_BITS + 2) / 3);

  localparam logic signed [SUM_BITS-1:0] ONE       = SUM_BITS'(2 ** (SAMPLE_BITS - 1));
  localparam logic signed [SUM_BITS-1:0] THREE_ONE = SUM_BITS'(3 * 2 ** (SAMPLE_BITS - 1));
  localparam logic signed [SUM_BITS-1:0] MAX_POS   = ONE - SUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] MAX_NEG   = -ONE;

  logic [EXT_BITS-1:0]        phase_ext;
  logic [TOP_BITS-1:0]        top;
  logic signed [SUM_BITS-1:0] top_s;
  logic signed [SUM_BITS-1:0] saw;
  logic signed [SUM_BITS-1:0] tri_wave;
  logic signed [SUM_BITS-1:0] square;
  logic [PW_BITS-1:0]         pw_clamp;
  logic [PHASE_BITS:0]        threshold;
  logic signed [SUM_BITS-1:0] sum;
  logic [1:0]                 count;
  logic                       neg;
  logic [SUM_BITS-1:0]        mag_full;
  logic [MAG_BITS-1:0]        mag;
  logic [PROD_BITS-1:0]       prod3;
  logic [MAG_BITS-1:0]        quot;
  logic signed [SUM_BITS-1:0] quot_s;
  logic signed [SUM_BITS-1:0] mixed;
  logic signed [SUM_BITS-1:0] clamped;

  // Take the top phase bits, padding on the right for a short phase
  assign phase_ext = EXT_BITS'(phase) << (EXT_BITS - PHASE_BITS);
  assign top       = phase_ext[EXT_BITS-1 -: TOP_BITS];
  assign top_s     = $signed({2'b00, top});

  // Saw rises from -1 to +1 over the cycle
  assign saw = $signed({3'b000, top[TOP_BITS-1:1]}) - ONE;

  // Triangle rises over the first half and falls over the second
  assign tri_wave = top[TOP_BITS-1] ? (THREE_ONE - top_s) : (top_s - ONE);

  // Square is high while the full phase is below the pulse width
  assign pw_clamp  = (cfg.pulse_width > PW_FULL) ? PW_FULL : cfg.pulse_width;
  assign threshold = (PHASE_BITS + 1)'(pw_clamp) << (PHASE_BITS - PW_FRAC_BITS);
  assign square    = ({1'b0, phase} < threshold) ? ONE : MAX_NEG;

  // Sum the enabled waves and count them
  assign sum = (cfg.saw_on      ? saw      : '0)
             + (cfg.square_on   ? square   : '0)
             + (cfg.triangle_on ? tri_wave : '0);
  assign count = 2'(cfg.saw_on) + 2'(cfg.square_on) + 2'(cfg.triangle_on);

  // Divide the magnitude so the quotient truncates toward zero
  assign neg      = sum[SUM_BITS-1];
  assign mag_full = neg ? $unsigned(-sum) : $unsigned(sum);
  assign mag      = mag_full[MAG_BITS-1:0];
  assign prod3    = PROD_BITS'(mag) * PROD_BITS'(RCP3);

  always_comb begin
    case (count)
      2'd2:    quot = mag >> 1;
      2'd3:    quot = prod3[PROD_BITS-1:RCP_BITS];
      default: quot = mag;
    endcase
  end

  assign quot_s = $signed({2'b00, quot});
  assign mixed  = neg ? -quot_s : quot_s;

  // Saturate at full scale
  always_comb begin
    if (mixed > MAX_POS) begin
      clamped = MAX_POS;
    end else if (mixed < MAX_NEG) begin
      clamped = MAX_NEG;
    end else begin
      clamped = mixed;
    end
  end

  // Load the output register whenever it is empty or being taken
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= phase_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && phase_valid) begin
      sample <= clamped[SAMPLE_BITS-1:0];
    end
  end

endmodule

>>> rtl/mixed_waveform_oscillator.sv
// Top level of the mixed waveform oscillator: saw, pulse and triangle mix from one NCO.
// Items pass the phase register, then the output register; one item per cycle while
// out_stall is low. The phase add sits in the input stage, the wave mix with its
// divide-by-three multiply sits between the phase and output registers.
// Reset (rst, synchronous): phase zero, no item staged, pulse width one half,
// phase step zero and all waves off.
module mixed_waveform_oscillator
  import mwo_pkg::*;
#(
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  cfg_t                  cfg;
  logic                  advance;
  logic                  phase_valid;
  logic [PHASE_BITS-1:0] phase;

  mwo_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mwo_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .phase_step  (cfg.phase_step),
    .advance     (advance),
    .phase_valid (phase_valid),
    .phase       (phase)
  );

  mwo_mix #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .phase_valid (phase_valid),
    .phase       (phase),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample)
  );

endmodule

>>> rtl/mwo_checker.sv
// Port-level assertions for the mixed waveform oscillator and their bind.
module mwo_checker
  import mwo_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample
);

  // Hold a stalled sample
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample))
    else $error("stalled sample changed or dropped");

  // Come out of reset with no sample pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("sample pending right after reset");

  // An empty output register never stalls the input
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  // An accepted item reaches the output through the phase register when the output moves
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output");

endmodule

bind mixed_waveform_oscillator mwo_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mwo_checker (.*);
